// ----- hw/rtl/sclp_pkg.sv -----
`timescale 1ns / 1ps

package sclp_pkg;

   localparam int VALUE_W  = 27;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 3;
   localparam int CSR_W    = 3;
   localparam int KWORD_W  = 64;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [STATUS_W-1:0] STATUS_MATCHED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic [CSR_W-1:0] CSR_KEYWORD_COUNT = 3'd0;
   // keyword registers follow the count register in order
   localparam logic [CSR_W-1:0] CSR_KEYWORD_0     = 3'd1;

   typedef logic [VALUE_W-1:0] value_type;

   function automatic logic is_line_end(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
   endfunction

   // keep the keyword bytes up to the first zero byte, clear the rest
   function automatic logic [KWORD_W-1:0] keyword_text(input logic [KWORD_W-1:0] w);
      logic [KWORD_W-1:0] r;
      logic               live;
      r    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (w[8*b +: 8] == 8'h00) live = 1'b0;
         if (live) r[8*b +: 8] = w[8*b +: 8];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/serial_command_line_parser.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/ready     req_rx_byte
// rsp_      out        rsp_valid/ready     rsp_status, rsp_command_index, rsp_value_0..3
// csr_      in         csr_valid/ready     csr_index, csr_data (always ready)
//
// A byte that does not end the line leaves intake open for the next byte.
// A line end walks the line store one byte a cycle through a single shared
// multiply-by-ten-and-add unit, stopping early once TOKENS tokens are found,
// then makes one keyword compare a cycle, then loads the output register.
// A line end on a full line store skips the walk and reports too long.
// Reset clears the fill count, keyword registers and all handshake state.
// A pending result does not stall byte intake; the next line end waits in its
// final cycle until the output register is free.

module serial_command_line_parser #(
   parameter int LINE_BYTES  = 32,
   parameter int TOKEN_CHARS = 8,
   parameter int TOKENS      = 4,
   parameter int KEYWORDS    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sclp_pkg::STATUS_W-1:0] rsp_status,
   output logic [sclp_pkg::CMD_W-1:0]    rsp_command_index,
   output logic [sclp_pkg::VALUE_W-1:0]  rsp_value_0,
   output logic [sclp_pkg::VALUE_W-1:0]  rsp_value_1,
   output logic [sclp_pkg::VALUE_W-1:0]  rsp_value_2,
   output logic [sclp_pkg::VALUE_W-1:0]  rsp_value_3,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sclp_pkg::CSR_W-1:0]    csr_index,
   input  logic [sclp_pkg::KWORD_W-1:0]  csr_data
);
   import sclp_pkg::*;

   localparam int AW  = $clog2(LINE_BYTES);
   localparam int CW  = $clog2(LINE_BYTES + 1);
   localparam int KCW = $clog2(TOKEN_CHARS + 1);
   localparam int KIW = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_MATCH = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                last_space_ff, last_space_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [KCW-1:0]      k_ff, k_in;
   logic [2:0]          tok_ff, tok_in;
   value_type           v_ff, v_in;
   logic                ok_ff, ok_in;
   logic [KWORD_W-1:0]  first_ff, first_in;
   value_type           val_ff [4];
   value_type           val_in [4];
   logic [2:0]          kwi_ff, kwi_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CMD_W-1:0]    res_cmd_ff, res_cmd_in;
   logic [2:0]          kw_count_ff, kw_count_in;
   logic [KWORD_W-1:0]  kw_ff [KEYWORDS];
   logic [KWORD_W-1:0]  kw_in [KEYWORDS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CMD_W-1:0]    rsp_cmd_ff, rsp_cmd_in;
   value_type           rsp_value_ff [4];
   value_type           rsp_value_in [4];

   logic [7:0]          line_mem [LINE_BYTES];
   logic [7:0]          rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [7:0]          mem_wdata;

   logic                req_xfer;
   logic [7:0]          c_in;
   logic [7:0]          scan_c;
   logic                tok_end;
   logic [3:0]          digit;
   logic [2:0]          kbyte;
   logic [2:0]          csr_slot;
   logic [2:0]          kw_used;
   value_type           mul_add;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign c_in      = req_rx_byte;

   assign rd_addr  = (state_ff == ST_IDLE) ? '0 : AW'(idx_ff + CW'(1));
   assign scan_c   = (idx_ff == fill_ff) ? CH_SPACE : rd_data_ff;
   assign tok_end  = (scan_c == CH_SPACE) || (k_ff == KCW'(TOKEN_CHARS));
   assign digit    = 4'(scan_c - "0");
   assign kbyte    = 3'(k_ff);
   assign csr_slot = csr_index - CSR_KEYWORD_0;
   assign kw_used  = (kw_count_ff > 3'(KEYWORDS)) ? 3'(KEYWORDS) : kw_count_ff;

   // shared unit: v * 10 + digit
   assign mul_add = VALUE_W'({v_ff, 3'b000}) + VALUE_W'({v_ff, 1'b0}) + VALUE_W'(digit);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      last_space_in = last_space_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      tok_in        = tok_ff;
      v_in          = v_ff;
      ok_in         = ok_ff;
      first_in      = first_ff;
      val_in        = val_ff;
      kwi_in        = kwi_ff;
      res_status_in = res_status_ff;
      res_cmd_in    = res_cmd_ff;
      kw_count_in   = kw_count_ff;
      kw_in         = kw_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_wdata     = c_in;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         if (csr_index == CSR_KEYWORD_COUNT) begin
            kw_count_in = csr_data[2:0];
         end else if (csr_slot < 3'(KEYWORDS)) begin
            kw_in[csr_slot[KIW-1:0]] = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (is_line_end(c_in)) begin
                  idx_in   = '0;
                  k_in     = '0;
                  tok_in   = '0;
                  v_in     = '0;
                  ok_in    = 1'b1;
                  first_in = '0;
                  for (int t = 0; t < 4; t++) val_in[t] = '0;
                  if (fill_ff == CW'(LINE_BYTES)) begin
                     res_status_in = STATUS_TOO_LONG;
                     res_cmd_in    = '0;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (fill_ff != CW'(LINE_BYTES)) begin
                  if ((c_in >= "0" && c_in <= "9") || (c_in >= "A" && c_in <= "Z")) begin
                     mem_we = 1'b1;
                  end else if (c_in >= "a" && c_in <= "z") begin
                     mem_we    = 1'b1;
                     mem_wdata = c_in - 8'd32;
                  end else if (c_in == CH_SPACE && fill_ff != '0 && !last_space_ff) begin
                     mem_we = 1'b1;
                  end
                  if (mem_we) begin
                     fill_in       = fill_ff + CW'(1);
                     last_space_in = (c_in == CH_SPACE);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (tok_end) begin
               // close the token; an overlong token loses this character
               val_in[tok_ff[1:0]] = v_ff;
               tok_in = tok_ff + 3'd1;
               k_in   = '0;
               v_in   = '0;
               ok_in  = 1'b1;
            end else begin
               k_in = k_ff + KCW'(1);
               if (ok_ff && scan_c >= "0" && scan_c <= "9") begin
                  v_in = mul_add;
               end else begin
                  ok_in = 1'b0;
               end
               if (tok_ff == 3'd0) first_in[{kbyte, 3'b000} +: 8] = scan_c;
            end
            if ((idx_ff == fill_ff) || (tok_end && (tok_ff + 3'd1 == 3'(TOKENS)))) begin
               kwi_in   = '0;
               state_in = ST_MATCH;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_MATCH: begin
            if (kwi_ff >= kw_used) begin
               res_status_in = STATUS_NO_MATCH;
               res_cmd_in    = '0;
               state_in      = ST_DONE;
            end else if (keyword_text(kw_ff[kwi_ff[KIW-1:0]]) == first_ff) begin
               res_status_in = STATUS_MATCHED;
               res_cmd_in    = kwi_ff;
               state_in      = ST_DONE;
            end else begin
               kwi_in = kwi_ff + 3'd1;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cmd_in    = res_cmd_ff;
               rsp_value_in  = val_ff;
               fill_in       = '0;
               last_space_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[fill_ff[AW-1:0]] <= mem_wdata;
      rd_data_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         last_space_ff <= 1'b0;
         kw_count_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < KEYWORDS; i++) kw_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         last_space_ff <= last_space_in;
         kw_count_ff   <= kw_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         kw_ff         <= kw_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      tok_ff        <= tok_in;
      v_ff          <= v_in;
      ok_ff         <= ok_in;
      first_ff      <= first_in;
      val_ff        <= val_in;
      kwi_ff        <= kwi_in;
      res_status_ff <= res_status_in;
      res_cmd_ff    <= res_cmd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_command_index = rsp_cmd_ff;
   assign rsp_value_0       = rsp_value_ff[0];
   assign rsp_value_1       = rsp_value_ff[1];
   assign rsp_value_2       = rsp_value_ff[2];
   assign rsp_value_3       = rsp_value_ff[3];

endmodule

// ----- hw/rtl/sclp_check.sv -----
`timescale 1ns / 1ps

module sclp_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [7:0]                    req_rx_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sclp_pkg::STATUS_W-1:0] rsp_status,
   input logic [sclp_pkg::CMD_W-1:0]    rsp_command_index,
   input logic [sclp_pkg::VALUE_W-1:0]  rsp_value_0,
   input logic [sclp_pkg::VALUE_W-1:0]  rsp_value_1,
   input logic [sclp_pkg::VALUE_W-1:0]  rsp_value_2,
   input logic [sclp_pkg::VALUE_W-1:0]  rsp_value_3
);
   import sclp_pkg::*;

   // a line end always leaves the idle state, so intake stops
   a_busy_after_line_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && is_line_end(req_rx_byte) |=> !req_ready)
      else $error("intake still open after line end");

   // a result is only loaded from the done state that ends a line's handling
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a line walk");

   a_too_long_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TOO_LONG |->
         rsp_command_index == '0 && rsp_value_0 == '0 && rsp_value_1 == '0 &&
         rsp_value_2 == '0 && rsp_value_3 == '0)
      else $error("overlong line result carries data");

   a_no_match_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_MATCH |-> rsp_command_index == '0)
      else $error("unmatched line carries a command index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_command_index) && $stable(rsp_value_0))
      else $error("stalled result changed");

endmodule

bind serial_command_line_parser sclp_check u_sclp_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_rx_byte       (req_rx_byte),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_command_index (rsp_command_index),
   .rsp_value_0       (rsp_value_0),
   .rsp_value_1       (rsp_value_1),
   .rsp_value_2       (rsp_value_2),
   .rsp_value_3       (rsp_value_3)
);

// ----- tb/sv/serial_command_line_parser_checker.sv -----
`timescale 1ns / 1ps

module serial_command_line_parser_checker #(
   parameter int LINE_BYTES  = 32,
   parameter int TOKEN_CHARS = 8,
   parameter int TOKENS      = 4,
   parameter int KEYWORDS    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sclp_pkg::STATUS_W-1:0] rsp_status,
   input  logic [sclp_pkg::CMD_W-1:0]    rsp_command_index,
   input  logic [sclp_pkg::VALUE_W-1:0]  rsp_value_0,
   input  logic [sclp_pkg::VALUE_W-1:0]  rsp_value_1,
   input  logic [sclp_pkg::VALUE_W-1:0]  rsp_value_2,
   input  logic [sclp_pkg::VALUE_W-1:0]  rsp_value_3,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [sclp_pkg::CSR_W-1:0]    csr_index,
   input  logic [sclp_pkg::KWORD_W-1:0]  csr_data,
   output int                            mismatch_count,
   output int                            lines_in_flight
);
   import sclp_pkg::*;

   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_Z = "Z";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_Z = "z";
   localparam logic [7:0] CASE_GAP   = 8'd32;

   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic [CMD_W-1:0]             command;
      logic [3:0][VALUE_W-1:0]      value;
   } line_result_type;

   logic [7:0]         line_buf [LINE_BYTES];
   int unsigned        line_fill;
   logic [2:0]         keywords_in_use;
   logic [KWORD_W-1:0] keyword_table [KEYWORDS];
   line_result_type    parsed_lines_q [$];

   function automatic logic [KWORD_W-1:0] keyword_body(input logic [KWORD_W-1:0] w);
      logic [KWORD_W-1:0] body;
      body = '0;
      for (int b = 0; b < 8; b++) begin
         if (w[8*b +: 8] == CH_NUL) break;
         body[8*b +: 8] = w[8*b +: 8];
      end
      return body;
   endfunction

   function automatic void store_byte(input logic [7:0] c);
      if (line_fill >= LINE_BYTES) return;
      if ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)) begin
         line_buf[line_fill] = c;
         line_fill++;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         line_buf[line_fill] = c - CASE_GAP;
         line_fill++;
      end else if (c == CH_SPACE && line_fill > 0 && line_buf[line_fill-1] != CH_SPACE) begin
         line_buf[line_fill] = c;
         line_fill++;
      end
   endfunction

   function automatic line_result_type parse_line();
      line_result_type    r;
      logic [7:0]         tok [TOKEN_CHARS];
      logic [7:0]         c;
      logic [KWORD_W-1:0] head;
      longint unsigned    v;
      bit                 digits;
      int                 k;
      int                 j;
      int                 n;
      r    = '0;
      head = '0;
      k    = 0;
      j    = 0;
      if (line_fill >= LINE_BYTES) begin
         r.status = STATUS_TOO_LONG;
         return r;
      end
      // a virtual space after the last byte closes the final token
      for (int i = 0; i <= line_fill; i++) begin
         c = (i < line_fill) ? line_buf[i] : CH_SPACE;
         if (j >= TOKENS) break;
         if (c == CH_SPACE || k >= TOKEN_CHARS) begin
            v      = 0;
            digits = 1'b1;
            for (int m = 0; m < k; m++) begin
               if (tok[m] < CH_ZERO || tok[m] > CH_NINE) digits = 1'b0;
               if (digits) v = v * 10 + 64'(tok[m] - CH_ZERO);
               if (j == 0) head[8*m +: 8] = tok[m];
            end
            if (j < 4) r.value[j] = v[VALUE_W-1:0];
            k = 0;
            j++;
         end else begin
            tok[k] = c;
            k++;
         end
      end
      n = (int'(keywords_in_use) > KEYWORDS) ? KEYWORDS : int'(keywords_in_use);
      r.status = STATUS_NO_MATCH;
      for (int l = 0; l < n; l++) begin
         if (keyword_body(keyword_table[l]) == head) begin
            r.status  = STATUS_MATCHED;
            r.command = l[CMD_W-1:0];
            break;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      line_result_type         want;
      logic [3:0][VALUE_W-1:0] got_value;
      if (reset) begin
         mismatch_count  = 0;
         line_fill       = 0;
         keywords_in_use = '0;
         foreach (keyword_table[i]) keyword_table[i] = '0;
         parsed_lines_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_lines_q.size() == 0) begin
               $error("result transfer with no line end pending: status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want      = parsed_lines_q.pop_front();
               got_value = {rsp_value_3, rsp_value_2, rsp_value_1, rsp_value_0};
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_command_index !== want.command) begin
                  $error("command_index: expected %0d, actual %0d",
                         want.command, rsp_command_index);
                  mismatch_count++;
               end
               for (int i = 0; i < 4; i++) begin
                  if (got_value[i] !== want.value[i]) begin
                     $error("value_%0d: expected %0d, actual %0d",
                            i, want.value[i], got_value[i]);
                     mismatch_count++;
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEYWORD_COUNT)
               keywords_in_use = csr_data[2:0];
            else if (int'(csr_index) - int'(CSR_KEYWORD_0) < KEYWORDS)
               keyword_table[int'(csr_index) - int'(CSR_KEYWORD_0)] = csr_data;
         end
         if (req_valid && req_ready) begin
            if (req_rx_byte == CH_LF || req_rx_byte == CH_CR || req_rx_byte == CH_NUL) begin
               parsed_lines_q.push_back(parse_line());
               line_fill = 0;
            end else begin
               store_byte(req_rx_byte);
            end
         end
      end
      lines_in_flight = parsed_lines_q.size();
   end

endmodule

// ----- tb/sv/serial_command_line_parser_tb.sv -----
`timescale 1ns / 1ps

module serial_command_line_parser_tb;
   import sclp_pkg::*;

   localparam int LINE_BYTES   = 32;
   localparam int TOKEN_CHARS  = 8;
   localparam int TOKENS       = 4;
   localparam int KEYWORDS     = 7;
   localparam int ITEM_TARGET  = 1950;
   localparam int PHASES       = 5;
   localparam int IDLE_PCT     = 19;
   localparam int DRAIN_CYCLES = LINE_BYTES + KEYWORDS + 3 + 16;
   localparam int VOCAB_N      = 12;
   localparam byte unsigned CASE_GAP = 8'd32;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [CMD_W-1:0]     rsp_command_index;
   logic [VALUE_W-1:0]   rsp_value_0;
   logic [VALUE_W-1:0]   rsp_value_1;
   logic [VALUE_W-1:0]   rsp_value_2;
   logic [VALUE_W-1:0]   rsp_value_3;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_index   = '0;
   logic [KWORD_W-1:0]   csr_data    = '0;
   int                   mismatch_count;
   int                   lines_in_flight;

   bit                   calm        = 1'b0;
   int                   items_sent  = 0;
   int                   lines_sent  = 0;
   logic [KWORD_W-1:0]   keyword_plan [KEYWORDS];
   byte unsigned         line_bytes [$];
   string                vocab [VOCAB_N] = '{"SET", "GET", "GO", "RUN", "STOP", "LED", "READ",
                                             "WRITE", "RESET", "ABCDEFGH", "MOTOR1", "X"};

   serial_command_line_parser u_dut (.*);

   serial_command_line_parser_checker #(
      .LINE_BYTES  (LINE_BYTES),
      .TOKEN_CHARS (TOKEN_CHARS),
      .TOKENS      (TOKENS),
      .KEYWORDS    (KEYWORDS)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic bit ignored_byte(input byte unsigned c);
      return !((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_NUL);
   endfunction

   function automatic byte unsigned junk_byte();
      byte unsigned c;
      do c = 8'($urandom_range(1, 255));
      while (!ignored_byte(c));
      return c;
   endfunction

   function automatic byte unsigned alnum_char();
      int r;
      r = $urandom_range(35);
      return 8'((r < 10) ? "0" + r : "A" + r - 10);
   endfunction

   function automatic byte unsigned mixed_case(input byte unsigned c);
      if (c >= "A" && c <= "Z" && $urandom_range(1) == 1) return c + CASE_GAP;
      return c;
   endfunction

   function automatic logic [KWORD_W-1:0] pack_word(input string s);
      logic [KWORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic logic [KWORD_W-1:0] pick_keyword();
      string              word;
      logic [KWORD_W-1:0] w;
      if ($urandom_range(9) == 0) return '0;
      word = vocab[$urandom_range(VOCAB_N - 1)];
      w    = pack_word(word);
      // garbage past the terminating zero byte must not take part in the compare
      if (word.len() < 7 && $urandom_range(2) == 0)
         w[KWORD_W-1 -: 8] = 8'($urandom_range(1, 255));
      return w;
   endfunction

   function automatic void put_char(input byte unsigned c);
      line_bytes.push_back(mixed_case(c));
      if ($urandom_range(99) < 5) line_bytes.push_back(junk_byte());
   endfunction

   function automatic void push_token();
      string word;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            word = vocab[$urandom_range(VOCAB_N - 1)];
            for (int i = 0; i < word.len(); i++) put_char(word[i]);
         end
         4, 5: repeat ($urandom_range(1, 9)) put_char(8'("0" + $urandom_range(9)));
         6: begin
            repeat ($urandom_range(1, 4)) put_char(8'("0" + $urandom_range(9)));
            repeat ($urandom_range(1, 3)) put_char(8'("A" + $urandom_range(25)));
         end
         7, 8: repeat ($urandom_range(1, 10)) put_char(alnum_char());
         default: repeat ($urandom_range(8, 9)) put_char("9");
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high for a back-to-back transfer
   task automatic send_byte(input byte unsigned b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (b == CH_LF || b == CH_CR || b == CH_NUL) lines_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line();
      int n_tok;
      int fill_to;
      line_bytes.delete();
      if ($urandom_range(99) < 4) begin
         repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SPACE);
         n_tok = $urandom_range(6);
         for (int t = 0; t < n_tok; t++) begin
            if (t > 0) repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
            push_token();
         end
         // pad to around the store's capacity now and then
         if ($urandom_range(99) < 8) begin
            fill_to = $urandom_range(LINE_BYTES - 2, LINE_BYTES + 8);
            while (line_bytes.size() < fill_to) put_char(alnum_char());
         end
         if ($urandom_range(3) == 0) line_bytes.push_back(CH_SPACE);
      end
      case ($urandom_range(2))
         0: line_bytes.push_back(CH_LF);
         1: line_bytes.push_back(CH_CR);
         default: line_bytes.push_back(CH_NUL);
      endcase
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] index, input logic [KWORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_keywords(input int count);
      for (int i = 0; i < KEYWORDS; i++)
         write_csr(CSR_W'(int'(CSR_KEYWORD_0) + i), keyword_plan[i]);
      write_csr(CSR_KEYWORD_COUNT, KWORD_W'(count));
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every pending result, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (lines_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         calm = (p == 2);
         case (p)
            0: begin
               keyword_plan[0] = pack_word("SET");
               keyword_plan[1] = pack_word("GET");
               keyword_plan[2] = pack_word("GO");
               keyword_plan[3] = '0;
               keyword_plan[4] = pack_word("ABCDEFGH");
               keyword_plan[5] = pack_word("RUN") | (64'hA5 << 40);
               keyword_plan[6] = '1;
               load_keywords(KEYWORDS);
               // empty line hits the empty keyword
               send_string("\n");
               // leading, junk and trailing bytes, lower case, NUL as line end
               send_string(" get");
               send_byte(8'hFF);
               send_string(" 7x ");
               send_byte(CH_NUL);
               // ninth character is lost, fifth token is ignored
               send_string("abcdefghi5 1 2 3\n");
            end
            1: begin
               foreach (keyword_plan[i]) keyword_plan[i] = {$urandom, $urandom};
               keyword_plan[0] = '1;
               keyword_plan[1] = '0;
               load_keywords(0);
            end
            default: begin
               foreach (keyword_plan[i]) keyword_plan[i] = pick_keyword();
               load_keywords((p == 2) ? 1 : (p == 3) ? $urandom_range(2, 6) : KEYWORDS);
            end
         endcase
         while (items_sent < (p + 1) * ITEM_TARGET / PHASES) send_line();
         settle();
      end
      $display("fed %0d bytes in %0d lines over %0d keyword setups,", items_sent, lines_sent,
               PHASES);
      $display("keyword counts from 0 to %0d, full-store lines and random stalls included",
               KEYWORDS);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
